// ----- src/vpt_pkg.sv -----
package vpt_pkg;

    localparam int DurW   = 16;
    localparam int LevelW = 5;
    localparam int CfgIdxW = 1;
    localparam int CfgDataW = 16;

    // request kinds carried in the mode field
    localparam logic MODE_REQUEST = 1'b0;
    localparam logic MODE_TICK    = 1'b1;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_TIMEOUT = 1'b0;
    localparam logic [CfgIdxW-1:0] CFG_DRIVE   = 1'b1;

    localparam logic [DurW-1:0]   RESET_TIMEOUT_MS = 16'd15000;
    localparam int                RESET_DRIVE_MV   = 3100;
    localparam logic [LevelW-1:0] LEVEL_MASK       = 5'h1F;
    localparam logic [LevelW-1:0] RESET_DRIVE_LEVEL =
        LevelW'(RESET_DRIVE_MV / 100) & LEVEL_MASK;

    // haptic stretch window and its sub-ranges
    localparam logic [DurW-1:0] HAPTIC_MIN = 16'd10;
    localparam logic [DurW-1:0] HAPTIC_LO  = 16'd40;
    localparam logic [DurW-1:0] HAPTIC_MID = 16'd60;
    localparam logic [DurW-1:0] HAPTIC_MAX = 16'd80;
    localparam logic [DurW-1:0] STRETCH_LO  = 16'd30;
    localparam logic [DurW-1:0] STRETCH_MID = 16'd20;
    localparam logic [DurW-1:0] STRETCH_HI  = 16'd10;

    typedef struct packed {
        logic            mode;
        logic [DurW-1:0] duration_ms;
    } in_item_t;

    typedef struct packed {
        logic              motor_on;
        logic [LevelW-1:0] drive_out;
        logic [DurW-1:0]   time_left_ms;
        logic              haptic_armed;
    } out_item_t;

    typedef struct packed {
        logic [DurW-1:0]   timeout_ms;
        logic [LevelW-1:0] drive_level;
    } cfg_regs_t;

endpackage

// ----- src/vpt_cfg.sv -----
module vpt_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [vpt_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [vpt_pkg::CfgDataW-1:0]  cfg_data,
    output vpt_pkg::cfg_regs_t            regs
);

    vpt_pkg::cfg_regs_t regs_reg;
    vpt_pkg::cfg_regs_t regs_next;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                vpt_pkg::CFG_TIMEOUT:
                begin
                    regs_next.timeout_ms = cfg_data;
                end
                vpt_pkg::CFG_DRIVE:
                begin
                    regs_next.drive_level =
                        cfg_data[vpt_pkg::LevelW-1:0] & vpt_pkg::LEVEL_MASK;
                end
                default:
                begin
                    regs_next = regs_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.timeout_ms  <= vpt_pkg::RESET_TIMEOUT_MS;
            regs_reg.drive_level <= vpt_pkg::RESET_DRIVE_LEVEL;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

    assign regs = regs_reg;

endmodule

// ----- src/vpt_step.sv -----
module vpt_step (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  vpt_pkg::in_item_t   item,
    input  vpt_pkg::cfg_regs_t  regs,
    output vpt_pkg::out_item_t  result
);

    logic [vpt_pkg::DurW-1:0] remaining_reg;
    logic [vpt_pkg::DurW-1:0] remaining_next;
    logic                     running_reg;
    logic                     running_next;
    logic                     haptic_reg;
    logic                     haptic_next;

    logic                     short_req;
    logic [vpt_pkg::DurW-1:0] stretch_add;
    logic [vpt_pkg::DurW-1:0] stretched;
    logic [vpt_pkg::DurW-1:0] clamped;
    logic [vpt_pkg::DurW-1:0] dec_val;

    always_comb
    begin
        short_req = (item.duration_ms > vpt_pkg::HAPTIC_MIN)
                 && (item.duration_ms <= vpt_pkg::HAPTIC_MAX);
        if (item.duration_ms <= vpt_pkg::HAPTIC_LO)
            stretch_add = vpt_pkg::STRETCH_LO;
        else if (item.duration_ms <= vpt_pkg::HAPTIC_MID)
            stretch_add = vpt_pkg::STRETCH_MID;
        else
            stretch_add = vpt_pkg::STRETCH_HI;
        // short requests are at most 80 so the sum stays in 16 bits
        stretched = short_req ? (item.duration_ms + stretch_add) : item.duration_ms;
        clamped   = (stretched > regs.timeout_ms) ? regs.timeout_ms : stretched;
        dec_val   = (remaining_reg != '0) ? (remaining_reg - 1'b1) : remaining_reg;
    end

    always_comb
    begin
        remaining_next = remaining_reg;
        running_next   = running_reg;
        haptic_next    = haptic_reg;
        case (item.mode)
            vpt_pkg::MODE_REQUEST:
            begin
                if (haptic_reg && (item.duration_ms == '0))
                begin
                    // disarming stop leaves the pulse alone
                    haptic_next = 1'b0;
                end
                else
                begin
                    haptic_next    = haptic_reg | short_req;
                    running_next   = (clamped != '0);
                    remaining_next = clamped;
                end
            end
            vpt_pkg::MODE_TICK:
            begin
                if (running_reg)
                begin
                    remaining_next = dec_val;
                    running_next   = (dec_val != '0);
                end
            end
            default:
            begin
                remaining_next = remaining_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remaining_reg <= '0;
            running_reg   <= 1'b0;
            haptic_reg    <= 1'b0;
        end
        else if (fire)
        begin
            remaining_reg <= remaining_next;
            running_reg   <= running_next;
            haptic_reg    <= haptic_next;
        end
    end

    always_comb
    begin
        result.motor_on     = running_next;
        result.drive_out    = running_next ? regs.drive_level : '0;
        result.time_left_ms = running_next ? remaining_next : '0;
        result.haptic_armed = haptic_next;
    end

    a_run_has_time: assert property (@(posedge clk) disable iff (!rst_n)
        running_reg |-> (remaining_reg != '0))
        else $error("running with zero time left");

    a_off_no_time: assert property (@(posedge clk) disable iff (!rst_n)
        !running_reg |-> (remaining_reg == '0))
        else $error("stopped with time left");

    a_tick_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (item.mode == vpt_pkg::MODE_TICK) && running_reg)
        |=> (remaining_reg == $past(remaining_reg) - 1'b1))
        else $error("tick did not count down by one");

    a_arm_on_request: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(haptic_reg) |-> $past(fire && (item.mode == vpt_pkg::MODE_REQUEST)))
        else $error("haptic flag armed without a request");

endmodule

// ----- src/vibration_pulse_timer.sv -----
// Vibration pulse timer. Each input transfer is either a vibration request
// (mode 0, duration in ms, 0 = stop) or a one millisecond tick (mode 1), and
// each yields exactly one result transfer with the motor state, drive level,
// remaining time and haptic flag after that item. A request in (10,80] ms is
// stretched and arms the haptic flag; every duration is clamped to timeout_ms.
// The block takes one item per clock while the result register is free or
// being drained: an input register feeds the state update logic, and the
// result lands in an output register. Configuration (index 0 timeout_ms,
// index 1 drive_level) should be written only while no item is in flight.
module vibration_pulse_timer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  vpt_pkg::in_item_t             in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output vpt_pkg::out_item_t            out_data,
    input  logic                          cfg_we,
    input  logic [vpt_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [vpt_pkg::CfgDataW-1:0]  cfg_data
);

    vpt_pkg::cfg_regs_t regs;
    vpt_pkg::in_item_t  in_item_reg;
    logic               in_valid_reg;
    vpt_pkg::out_item_t out_item_reg;
    logic               out_valid_reg;
    vpt_pkg::out_item_t step_result;
    logic               out_free;
    logic               advance;

    assign out_free = !out_valid_reg || out_ready;
    assign advance  = in_valid_reg && out_free;
    assign in_ready = !in_valid_reg || advance;

    vpt_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .regs      (regs)
    );

    vpt_step u_step (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (in_item_reg),
        .regs   (regs),
        .result (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (out_free)
                out_valid_reg <= in_valid_reg;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_item_reg <= in_data;
        if (advance)
            out_item_reg <= step_result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

endmodule

// ----- sim/vibration_pulse_timer_test.sv -----
`timescale 1ns / 1ps

module vibration_pulse_timer_test;

    localparam int QuietLimit = 4000;
    localparam int PhaseItems = 145;
    localparam int LongHold   = 400;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                        in_valid = 1'b0;
    logic                        in_ready;
    vpt_pkg::in_item_t           in_data = '0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    vpt_pkg::out_item_t          out_data;
    logic                        cfg_we = 1'b0;
    logic [vpt_pkg::CfgIdxW-1:0]  cfg_index = '0;
    logic [vpt_pkg::CfgDataW-1:0] cfg_data = '0;

    vibration_pulse_timer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // pulse timer state mirrored for prediction
    logic [vpt_pkg::DurW-1:0]   timeout_reg = vpt_pkg::RESET_TIMEOUT_MS;
    logic [vpt_pkg::LevelW-1:0] level_reg   = vpt_pkg::RESET_DRIVE_LEVEL;
    logic [vpt_pkg::DurW-1:0]   pulse_left  = '0;
    logic                       pulse_on    = 1'b0;
    logic                       haptic_set  = 1'b0;

    vpt_pkg::in_item_t  pending_q[$];
    vpt_pkg::out_item_t status_q[$];

    int   queued = 0;
    int   results_seen = 0;
    int   error_count = 0;
    int   quiet_cycles = 0;
    int   send_gap = 0;
    int   hold_left = 0;
    int   hold_stage = 0;
    logic req_taken = 1'b0;
    logic idle_on = 1'b1;
    vpt_pkg::out_item_t want;

    function automatic vpt_pkg::out_item_t predict_pulse(vpt_pkg::in_item_t item);
        logic [vpt_pkg::DurW:0] span;
        vpt_pkg::out_item_t     res;
        if (item.mode == vpt_pkg::MODE_REQUEST)
        begin
            if (haptic_set && item.duration_ms == '0)
            begin
                // a stop while armed only disarms
                haptic_set = 1'b0;
            end
            else
            begin
                span = {1'b0, item.duration_ms};
                if (span > vpt_pkg::HAPTIC_MIN && span <= vpt_pkg::HAPTIC_MAX)
                begin
                    haptic_set = 1'b1;
                    if (span <= vpt_pkg::HAPTIC_LO)
                        span = span + vpt_pkg::STRETCH_LO;
                    else if (span <= vpt_pkg::HAPTIC_MID)
                        span = span + vpt_pkg::STRETCH_MID;
                    else
                        span = span + vpt_pkg::STRETCH_HI;
                end
                if (span > {1'b0, timeout_reg})
                    span = {1'b0, timeout_reg};
                if (span == '0)
                begin
                    pulse_on   = 1'b0;
                    pulse_left = '0;
                end
                else
                begin
                    pulse_on   = 1'b1;
                    pulse_left = span[vpt_pkg::DurW-1:0];
                end
            end
        end
        else if (pulse_on)
        begin
            if (pulse_left != '0)
                pulse_left = pulse_left - 1'b1;
            if (pulse_left == '0)
                pulse_on = 1'b0;
        end
        res.motor_on     = pulse_on;
        res.drive_out    = pulse_on ? level_reg : '0;
        res.time_left_ms = pulse_on ? pulse_left : '0;
        res.haptic_armed = haptic_set;
        return res;
    endfunction

    task automatic queue_request(logic [vpt_pkg::DurW-1:0] dur);
        vpt_pkg::in_item_t item;
        item.mode        = vpt_pkg::MODE_REQUEST;
        item.duration_ms = dur;
        pending_q.push_back(item);
        queued++;
    endtask

    task automatic queue_ticks(int count);
        vpt_pkg::in_item_t item;
        for (int i = 0; i < count; i++)
        begin
            item.mode        = vpt_pkg::MODE_TICK;
            item.duration_ms = vpt_pkg::DurW'($urandom);
            pending_q.push_back(item);
            queued++;
        end
    endtask

    // one request followed by a countdown, or a bit of noise
    task automatic queue_sequence();
        logic [vpt_pkg::DurW-1:0] edges[8];
        logic [vpt_pkg::DurW-1:0] dur;
        int                       pick;
        int                       span;
        vpt_pkg::in_item_t        item;
        edges = '{16'd10, 16'd11, 16'd40, 16'd41, 16'd60, 16'd61, 16'd80, 16'd81};
        pick = $urandom_range(0, 9);
        case (pick)
            0:
            begin
                item = vpt_pkg::in_item_t'($urandom);
                pending_q.push_back(item);
                queued++;
                return;
            end
            1: dur = '0;
            2: dur = edges[$urandom_range(0, 7)];
            3, 4: dur = vpt_pkg::DurW'($urandom_range(11, 80));
            5, 6: dur = vpt_pkg::DurW'($urandom_range(1, 200));
            7: dur = vpt_pkg::DurW'($urandom);
            default: dur = vpt_pkg::DurW'($urandom_range(0, 12));
        endcase
        queue_request(dur);
        span = (dur > 130) ? 130 : int'(dur);
        if (pick == 8)
            queue_ticks($urandom_range(0, 3));
        else
            queue_ticks($urandom_range(0, span + 34));
    endtask

    task automatic write_reg(logic [vpt_pkg::CfgIdxW-1:0] idx,
                             logic [vpt_pkg::CfgDataW-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == vpt_pkg::CFG_TIMEOUT)
            timeout_reg = val;
        else if (idx == vpt_pkg::CFG_DRIVE)
            level_reg = val[vpt_pkg::LevelW-1:0] & vpt_pkg::LEVEL_MASK;
    endtask

    task automatic drain();
        while (pending_q.size() != 0 || in_valid || status_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // input driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || req_taken)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_q.size() != 0)
                begin
                    in_data  <= pending_q.pop_front();
                    in_valid <= 1'b1;
                    if (idle_on && $urandom_range(0, 5) == 0)
                        send_gap <= $urandom_range(1, 19);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result receiver with random stalls and two long hold-offs
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else if ((hold_stage == 0 && results_seen >= 150) ||
                     (hold_stage == 1 && results_seen >= 500))
            begin
                hold_stage <= hold_stage + 1;
                hold_left  <= LongHold - 1;
                out_ready  <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                hold_left <= $urandom_range(0, 18);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // transfer monitor and checker
    always @(posedge clk)
    begin
        req_taken <= in_valid && in_ready;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (status_q.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("unexpected result: on=%0d drive=%0d left=%0d armed=%0d",
                                 out_data.motor_on, out_data.drive_out,
                                 out_data.time_left_ms, out_data.haptic_armed);
                end
                else
                begin
                    want = status_q.pop_front();
                    if (out_data.motor_on !== want.motor_on ||
                        out_data.drive_out !== want.drive_out ||
                        out_data.time_left_ms !== want.time_left_ms ||
                        out_data.haptic_armed !== want.haptic_armed)
                    begin
                        error_count++;
                        if (error_count <= 10)
                            $display("mismatch %0d: exp %0d %0d %0d %0d, got %0d %0d %0d %0d",
                                     results_seen, want.motor_on, want.drive_out,
                                     want.time_left_ms, want.haptic_armed,
                                     out_data.motor_on, out_data.drive_out,
                                     out_data.time_left_ms, out_data.haptic_armed);
                    end
                end
            end
            if (in_valid && in_ready)
                status_q.push_back(predict_pulse(in_data));
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QuietLimit)
            begin
                $display("vibration_pulse_timer_test: done, errors");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part at reset settings
        queue_request(16'd0);
        queue_ticks(1);
        queue_request(16'd10);
        queue_ticks(1);
        queue_request(16'd11);
        queue_ticks(1);
        queue_request(16'd0);       // disarming stop, pulse keeps going
        queue_ticks(1);
        queue_request(16'd0);       // plain stop
        queue_request(16'd40);
        queue_request(16'd41);
        queue_request(16'd60);
        queue_request(16'd61);
        queue_request(16'd80);
        queue_request(16'd81);
        queue_request(16'hFFFF);    // clamped to the timeout
        queue_ticks(1);
        queue_request(16'd1);
        queue_ticks(2);             // counts to zero, then a tick while off
        drain();

        write_reg(vpt_pkg::CFG_TIMEOUT, 16'd0);
        write_reg(vpt_pkg::CFG_DRIVE, 16'd0);
        queue_request(16'd5);       // zero timeout keeps the motor off
        queue_request(16'd20);
        queue_request(16'd0);
        drain();

        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(vpt_pkg::CFG_TIMEOUT, 16'hFFFF);
                    write_reg(vpt_pkg::CFG_DRIVE, 16'd31);
                end
                1:
                begin
                    write_reg(vpt_pkg::CFG_TIMEOUT, 16'd0);
                    write_reg(vpt_pkg::CFG_DRIVE, 16'd0);
                end
                2:
                begin
                    write_reg(vpt_pkg::CFG_TIMEOUT, 16'd50);
                    write_reg(vpt_pkg::CFG_DRIVE, 16'd17);
                end
                3:
                begin
                    write_reg(vpt_pkg::CFG_TIMEOUT,
                              vpt_pkg::CfgDataW'($urandom_range(1, 300)));
                    write_reg(vpt_pkg::CFG_DRIVE,
                              vpt_pkg::CfgDataW'($urandom_range(0, 31)));
                end
                default:
                begin
                    write_reg(vpt_pkg::CFG_TIMEOUT, vpt_pkg::RESET_TIMEOUT_MS);
                    write_reg(vpt_pkg::CFG_DRIVE, 16'd1);
                    idle_on = 1'b0;
                end
            endcase
            begin : fill_phase
                int start;
                start = queued;
                while (queued - start < PhaseItems)
                    queue_sequence();
            end
            drain();
        end

        repeat (10) @(negedge clk);
        if (status_q.size() != 0)
            error_count += status_q.size();
        if (error_count == 0)
            $display("vibration_pulse_timer_test: done, clean");
        else
            $display("vibration_pulse_timer_test: done, errors");
        $finish;
    end

endmodule
